>>> rtl/core/xorshift128_ranged_generator_macros.svh
// Assertion macros shared by the generator RTL; they sample on clk and hold off during rst.
`ifndef XORSHIFT128_RANGED_GENERATOR_MACROS_SVH
`define XORSHIFT128_RANGED_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define XRG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define XRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/xrg_pkg.sv
// Types and constants of the ranged xorshift128 generator.
package xrg_pkg;

  localparam int WORD_W = 32;
  localparam int CMD_W  = 2;
  localparam int CFG_IDX_W = 1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CMD_W-1:0]  cmd_t;

  localparam cmd_t CMD_RAW    = 2'd0;
  localparam cmd_t CMD_RANGED = 2'd1;
  localparam cmd_t CMD_RESEED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

  localparam word_t RESET_A = 32'd123456789;
  localparam word_t RESET_B = 32'd362436069;
  localparam word_t RESET_C = 32'd521288629;
  localparam word_t RESET_D = 32'd88675123;
  localparam word_t RESET_RANGE_LOW  = 32'd0;
  localparam word_t RESET_RANGE_HIGH = 32'hFFFF_FFFF;

  localparam int SHIFT_A  = 11;
  localparam int SHIFT_D  = 19;
  localparam int SHIFT_T  = 8;

  // Which state word takes the fresh step output during a reseed.
  typedef enum logic [1:0] {
    XS_NONE = 2'd0,
    XS_A    = 2'd1,
    XS_B    = 2'd2,
    XS_C    = 2'd3
  } xor_sel_t;

  typedef struct packed {
    logic     load;
    logic     step;
    xor_sel_t xor_sel;
    logic     fold;
  } state_ctl_t;

endpackage

>>> rtl/core/xrg_channels.sv
// Valid/ready channel interfaces for command words and result words.
interface xrg_in_if;
  logic             valid;
  logic             ready;
  xrg_pkg::cmd_t    cmd;
  xrg_pkg::word_t   seed;

  modport source (output valid, output cmd, output seed, input ready);
  modport sink   (input valid, input cmd, input seed, output ready);
endinterface

interface xrg_out_if;
  logic             valid;
  logic             ready;
  xrg_pkg::word_t   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/core/xrg_state.sv
// Xorshift128 state words with the step, seed-load and reseed mixing datapath.
module xrg_state (
  input  logic                clk,
  input  logic                rst,
  input  xrg_pkg::state_ctl_t ctl,
  input  xrg_pkg::word_t      seed,
  output xrg_pkg::word_t      word_d_out
);
  import xrg_pkg::*;

  word_t word_a, word_b, word_c, word_d;
  word_t t, f;

  always_comb begin
    t = word_a ^ (word_a << SHIFT_A);
    f = word_d ^ (word_d >> SHIFT_D) ^ t ^ (t >> SHIFT_T);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_a <= RESET_A;
      word_b <= RESET_B;
      word_c <= RESET_C;
      word_d <= RESET_D;
    end else if (ctl.load) begin
      word_d <= seed;
    end else if (ctl.step) begin
      // shift down; during reseed the shifted-in word also takes f
      word_a <= word_b ^ ((ctl.xor_sel == XS_A) ? f : '0);
      word_b <= word_c ^ ((ctl.xor_sel == XS_B) ? f : '0);
      word_c <= word_d ^ ((ctl.xor_sel == XS_C) ? f : '0);
      word_d <= f;
    end else if (ctl.fold) begin
      word_d <= word_d ^ word_a;
    end
  end

  assign word_d_out = word_d;

endmodule

>>> rtl/core/xrg_remainder.sv
// Restoring shift-subtract remainder unit, one dividend bit per cycle.
`include "xorshift128_ranged_generator_macros.svh"

module xrg_remainder (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  xrg_pkg::word_t dividend,
  input  xrg_pkg::word_t divisor,
  output logic           busy,
  output logic           done,
  output xrg_pkg::word_t rem
);
  import xrg_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_W - 1);

  word_t            quo;
  word_t            div;
  logic [CNT_W-1:0] cnt;
  logic [WORD_W:0]  trial;
  logic [WORD_W:0]  diff;
  logic             fits;

  always_comb begin
    trial = {rem, quo[WORD_W-1]};
    diff  = trial - {1'b0, div};
    fits  = trial >= {1'b0, div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      div <= divisor;
    end else if (busy) begin
      // rem stays below div, so the difference fits in one word
      rem <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      quo <= quo << 1;
    end
  end

  `XRG_ASSERT_NOW(a_no_restart, start, !busy, "remainder restarted while busy")
  `XRG_ASSERT_NEXT(a_done_idle, done, !busy, "remainder busy after done")
  `XRG_ASSERT_NOW(a_rem_bound, busy && !start, rem < div, "partial remainder out of bound")

endmodule

>>> rtl/core/xorshift128_ranged_generator.sv
// Top level of the ranged xorshift128 generator: sequencer, range registers, output word.
//
// Ranged xorshift128 generator. Each command word on in_ch is taken only while the
// sequencer is idle. A raw draw steps the state, then loads its result word in the
// done state once the result slot is free. A ranged draw over a nonzero span runs step,
// remainder start, the bit-serial remainder unit, then done and output-load. A full
// 2^32 span returns the raw draw. A reseed runs seed load, three steps and a fold before
// the next command word is taken, and gives no result. cmd 3 is dropped. The result
// register holds a finished word until out_ch takes it, and the next command can be
// accepted meanwhile. range_low and range_high (cfg_index 0 and 1) are written through
// cfg_we; the user must write them only while idle, as the block does not enforce it.
`include "xorshift128_ranged_generator_macros.svh"

module xorshift128_ranged_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [xrg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  xrg_pkg::word_t                     cfg_data,
  xrg_in_if.sink                             in_ch,
  xrg_out_if.source                          out_ch
);
  import xrg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STEP  = 5'b00010,
    S_DIVGO = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } seq_state_t;

  seq_state_t   state, state_next;
  cmd_t         cmd_r;
  logic [1:0]   cnt;
  word_t        range_low, range_high;
  word_t        span;
  logic         span_zero;
  state_ctl_t   ctl;
  word_t        word_d;
  logic         div_start, div_busy, div_done;
  word_t        rem;
  logic         out_valid;
  word_t        out_value;
  logic         accept;
  logic         slot_free;
  logic         fold;
  // Fold pending flag: the last reseed step and the fold share no cycle.
  logic         fold_pend;
  state_ctl_t   ctl_mux;

  assign span      = range_high - range_low + 1'b1;
  assign span_zero = (span == '0);
  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid || out_ch.ready;

  assign in_ch.ready  = (state == S_IDLE) && !fold_pend;
  assign out_ch.valid = out_valid;
  assign out_ch.value = out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= RESET_RANGE_LOW;
      range_high <= RESET_RANGE_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.xor_sel = XS_NONE;
    div_start   = 1'b0;
    fold        = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.cmd)
            CMD_RAW, CMD_RANGED: state_next = S_STEP;
            CMD_RESEED: begin
              ctl.load   = 1'b1;
              state_next = S_STEP;
            end
            default: ;
          endcase
        end
      end
      S_STEP: begin
        ctl.step = 1'b1;
        if (cmd_r == CMD_RESEED) begin
          case (cnt)
            2'd0:    ctl.xor_sel = XS_A;
            2'd1:    ctl.xor_sel = XS_B;
            default: ctl.xor_sel = XS_C;
          endcase
          if (cnt == 2'd2) begin
            // fold of word_d runs in the idle cycle that follows; input held off then
            state_next = S_IDLE;
            fold       = 1'b1;
          end
        end else if (cmd_r == CMD_RANGED && !span_zero) begin
          state_next = S_DIVGO;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIVGO: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_mux = ctl;
    if (fold_pend) ctl_mux.fold = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      fold_pend <= 1'b0;
    end else begin
      state     <= state_next;
      fold_pend <= fold;
      if (accept) cnt <= '0;
      else if (state == S_STEP) cnt <= cnt + 1'b1;
      if (state == S_DONE && slot_free) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cmd_r <= in_ch.cmd;
    if (state == S_DONE && slot_free) begin
      out_value <= (cmd_r == CMD_RANGED && !span_zero) ? range_low + rem : word_d;
    end
  end

  xrg_state u_state (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_mux),
    .seed       (in_ch.seed),
    .word_d_out (word_d)
  );

  xrg_remainder u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (word_d),
    .divisor  (span),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (rem)
  );

  `XRG_ASSERT_NOW(a_ready_div_idle, in_ch.ready, !div_busy, "command taken while dividing")
  `XRG_ASSERT_NOW(a_done_in_div, div_done, state == S_DIV, "remainder done outside divide")
  `XRG_ASSERT_NEXT(a_result_loaded, state == S_DONE && slot_free, out_valid, "result not loaded")
  `XRG_ASSERT_NOW(a_fold_alone, fold_pend, !accept || in_ch.cmd != CMD_RESEED, "fold overlaps load")

endmodule

>>> sim/xorshift128_ranged_generator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ranged xorshift128 generator: directed and random command words.
module xorshift128_ranged_generator_test;
  import xrg_pkg::*;

  localparam cmd_t CMD_UNUSED    = 2'd3;
  localparam int   CYCLE_LIMIT   = 500000;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   HOLD_CYCLES   = 300;
  localparam int   PHASES        = 12;
  localparam int   PHASE_ITEMS   = 96;
  localparam int   MAX_REPORTS   = 200;

  typedef enum int {
    SPAN_FULL,
    SPAN_NARROW,
    SPAN_ANY,
    SPAN_POW2,
    SPAN_WRAPPED,
    SPAN_FROM_ZERO
  } span_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_data;

  xrg_in_if  in_ch ();
  xrg_out_if out_ch ();

  xorshift128_ranged_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // generator state and range as the block should hold them
  word_t gen_a, gen_b, gen_c, gen_d;
  word_t cur_low, cur_high;
  word_t pending_values[$];

  int          error_count   = 0;
  bit          src_idle_on   = 1'b0;
  bit          sink_idle_on  = 1'b0;
  int unsigned sink_hold_req = 0;
  int unsigned cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t advance_state();
    word_t t;
    t = gen_a ^ (gen_a << SHIFT_A);
    gen_a = gen_b;
    gen_b = gen_c;
    gen_c = gen_d;
    gen_d = gen_d ^ (gen_d >> SHIFT_D) ^ t ^ (t >> SHIFT_T);
    return gen_d;
  endfunction

  function automatic void apply_command(cmd_t c, word_t s);
    word_t r;
    word_t span;
    word_t v;
    case (c)
      CMD_RAW: begin
        r = advance_state();
        pending_values.push_back(r);
      end
      CMD_RANGED: begin
        r = advance_state();
        span = cur_high - cur_low + 32'd1;
        if (span == 32'd0) begin
          v = r;
        end else begin
          v = cur_low + (r % span);
        end
        pending_values.push_back(v);
      end
      CMD_RESEED: begin
        gen_d = s;
        r = advance_state();
        gen_a = gen_a ^ r;
        r = advance_state();
        gen_b = gen_b ^ r;
        r = advance_state();
        gen_c = gen_c ^ r;
        gen_d = gen_d ^ gen_a;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_word(cmd_t c, word_t s);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.seed  <= s;
    do @(posedge clk); while (!in_ch.ready);
    apply_command(c, s);
  endtask

  // drain all results, then let a trailing reseed or dropped word finish
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_range(word_t lo, word_t hi);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_RANGE_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_RANGE_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_low  = lo;
    cur_high = hi;
  endtask

  function automatic cmd_t pick_cmd();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return CMD_RAW;
    if (roll < 80) return CMD_RANGED;
    if (roll < 92) return CMD_RESEED;
    return CMD_UNUSED;
  endfunction

  task automatic check_reset_draws();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_word(CMD_RAW, 32'd0);
    send_word(CMD_RAW, '1);
    // reset range covers all of 2^32, so ranged draws return the raw word
    send_word(CMD_RANGED, 32'd0);
    send_word(CMD_RANGED, '1);
    send_word(CMD_RESEED, 32'd0);
    send_word(CMD_RAW, $urandom);
  endtask

  task automatic check_range_extremes();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    write_range(32'd0, 32'd0);
    send_word(CMD_RANGED, $urandom);
    send_word(CMD_RANGED, $urandom);
    write_range('1, '1);
    send_word(CMD_RANGED, $urandom);
    write_range(32'd0, 32'hFFFF_FFFE);
    send_word(CMD_RANGED, $urandom);
    // inverted: span of two that wraps past the top
    write_range('1, 32'd0);
    send_word(CMD_RANGED, $urandom);
    send_word(CMD_RANGED, $urandom);
    write_range(32'd100, 32'd10);
    send_word(CMD_RANGED, $urandom);
    // inverted by one: span wraps to zero
    write_range(32'd1, 32'd0);
    send_word(CMD_RANGED, $urandom);
    write_range(32'd0, '1);
    send_word(CMD_RANGED, $urandom);
  endtask

  task automatic check_reseed_and_unused();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b1;
    send_word(CMD_RESEED, '1);
    send_word(CMD_RAW, $urandom);
    send_word(CMD_UNUSED, $urandom);
    send_word(CMD_RAW, $urandom);
    send_word(CMD_RESEED, 32'hA5A5_A5A5);
    send_word(CMD_RANGED, $urandom);
    send_word(CMD_RESEED, $urandom);
    send_word(CMD_RESEED, $urandom);
    send_word(CMD_RAW, $urandom);
  endtask

  task automatic check_random_traffic();
    int unsigned n;
    word_t       lo;
    word_t       hi;
    span_mode_t  mode;
    cmd_t        c;
    for (int phase = 0; phase < PHASES; phase++) begin
      mode = (phase < 6) ? span_mode_t'(phase) : span_mode_t'($urandom_range(0, 5));
      case (mode)
        SPAN_FULL: begin
          lo = 32'd0;
          hi = '1;
        end
        SPAN_NARROW: begin
          lo = $urandom;
          hi = lo + $urandom_range(0, 15);
        end
        SPAN_ANY: begin
          lo = $urandom;
          hi = $urandom;
        end
        SPAN_POW2: begin
          lo = $urandom_range(0, 255);
          hi = lo + (word_t'(1) << $urandom_range(0, 31)) - word_t'(1);
        end
        SPAN_WRAPPED: begin
          lo = '1 - word_t'($urandom_range(0, 3));
          hi = $urandom_range(0, 3);
        end
        default: begin
          lo = 32'd0;
          hi = $urandom;
        end
      endcase
      write_range(lo, hi);
      src_idle_on  = (phase % 3) != 0;
      sink_idle_on = (phase % 4) != 1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        c = pick_cmd();
        send_word(c, $urandom);
        if (c != CMD_UNUSED) n++;
      end
    end
  endtask

  task automatic check_output_stall();
    wait_idle();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    sink_hold_req = HOLD_CYCLES;
    // sender keeps offering while the sink holds off; input must back up
    repeat (24) send_word(($urandom_range(0, 1) != 0) ? CMD_RAW : CMD_RANGED, $urandom);
  endtask

  task automatic check_source_pause();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (int round = 0; round < 3; round++) begin
      write_range($urandom_range(0, 1000), $urandom_range(1000, 5000));
      repeat (20) send_word(pick_cmd(), $urandom);
      wait_idle();
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          stall_left = sink_idle_on ? $urandom_range(0, 7) : 0;
        end
        if (sink_hold_req != 0) begin
          stall_left = sink_hold_req;
          sink_hold_req = 0;
        end
        if (stall_left != 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : result_checker
    word_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_values.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result word, expected none, actual %h",
                     $time, out_ch.value);
        end else begin
          want = pending_values.pop_front();
          if (out_ch.value !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: value mismatch, expected %h, actual %h",
                       $time, want, out_ch.value);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d words outstanding",
             $time, cycle_count, pending_values.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_RANGE_LOW;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= CMD_RAW;
    in_ch.seed  <= '0;
    gen_a    = RESET_A;
    gen_b    = RESET_B;
    gen_c    = RESET_C;
    gen_d    = RESET_D;
    cur_low  = RESET_RANGE_LOW;
    cur_high = RESET_RANGE_HIGH;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    check_reset_draws();
    check_range_extremes();
    check_reseed_and_unused();
    check_random_traffic();
    check_output_stall();
    check_source_pause();
    wait_idle();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
